@@ src/mac_learning_bridge_table_assert.svh @@
// assertion macros shared by the bridge table rtl
`ifndef MAC_LEARNING_BRIDGE_TABLE_ASSERT_SVH
`define MAC_LEARNING_BRIDGE_TABLE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MLBT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MLBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/mlbt_pkg.sv @@
package mlbt_pkg;

   localparam int MAC_W     = 48;
   localparam int PORT_W    = 3;
   localparam int OUT_W     = 8;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_TABLE_ENTRIES = 64;
   localparam int DEF_NUM_PORTS     = 8;
   localparam int DEF_AGE_BITS      = 8;

   localparam logic [CSR_W-1:0] LEARN_TIMEOUT_RST = 8'd30;
   localparam logic [CSR_W-1:0] ENTRY_TTL_RST     = 8'd100;
   localparam logic [CSR_W-1:0] ACTIVE_MASK_RST   = 8'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_TTL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_MASK   = 2'd2;

   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic              dst_flood;
      logic [PORT_W-1:0] in_port;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] out_port_mask;
      logic             dest_found;
      logic             learn_dropped;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear_wr;
      logic load;
      logic rd;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cnt_last;
      logic out_free;
   } stat_type;

endpackage

@@ src/mlbt_ctrl.sv @@
module mlbt_ctrl import mlbt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.cnt_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign cmd.clear_wr = (state_ff == ST_CLEAR);
   assign cmd.load     = (state_ff == ST_IDLE) && req_valid;
   assign cmd.rd       = (state_ff == ST_SCAN);
   assign cmd.finish   = (state_ff == ST_FINISH) && stat.out_free;

endmodule

@@ src/mlbt_dpath.sv @@
module mlbt_dpath import mlbt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int NUM_PORTS     = DEF_NUM_PORTS,
   parameter int AGE_BITS      = DEF_AGE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output stat_type             stat,
   input  req_type              req_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = (AGE_BITS > CSR_W) ? AGE_BITS : CSR_W;
   localparam int RANGE_BITS = (NUM_PORTS >= OUT_W) ? OUT_W : NUM_PORTS;
   localparam logic [OUT_W-1:0] PORT_RANGE = {OUT_W{1'b1}} >> (OUT_W - RANGE_BITS);
   localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
   localparam logic [IW-1:0] LAST_ADDR = IW'(TABLE_ENTRIES - 1);

   // configuration
   logic [CSR_W-1:0] learn_timeout_ff, learn_timeout_in;
   logic [CSR_W-1:0] entry_ttl_ff, entry_ttl_in;
   logic [CSR_W-1:0] active_mask_ff, active_mask_in;

   always_comb begin
      learn_timeout_in = learn_timeout_ff;
      entry_ttl_in     = entry_ttl_ff;
      active_mask_in   = active_mask_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LEARN_TIMEOUT: learn_timeout_in = csr_wdata;
            CSR_ENTRY_TTL:     entry_ttl_in     = csr_wdata;
            CSR_ACTIVE_MASK:   active_mask_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         learn_timeout_ff <= LEARN_TIMEOUT_RST;
         entry_ttl_ff     <= ENTRY_TTL_RST;
         active_mask_ff   <= ACTIVE_MASK_RST;
      end else begin
         learn_timeout_ff <= learn_timeout_in;
         entry_ttl_ff     <= entry_ttl_in;
         active_mask_ff   <= active_mask_in;
      end
   end

   // item held for the whole scan
   req_type item_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_payload;
   end

   // table address counter, shared by the clearing pass and the scan
   logic [IW-1:0] cnt_ff, cnt_in;
   logic          cnt_last;

   assign cnt_last = (cnt_ff == LAST_ADDR);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_wr || cmd.rd) cnt_in = cnt_last ? '0 : cnt_ff + IW'(1);
   end

   logic          rd_valid_ff;
   logic [IW-1:0] rd_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         rd_valid_ff <= cmd.rd;
      end
      rd_addr_ff <= cnt_ff;
   end

   // table memory
   logic                mem_valid [TABLE_ENTRIES];
   logic [MAC_W-1:0]    mem_mac   [TABLE_ENTRIES];
   logic [PORT_W-1:0]   mem_port  [TABLE_ENTRIES];
   logic [AGE_BITS-1:0] mem_age   [TABLE_ENTRIES];

   logic                rdv_ff;
   logic [MAC_W-1:0]    rdmac_ff;
   logic [PORT_W-1:0]   rdport_ff;
   logic [AGE_BITS-1:0] rdage_ff;

   logic                wr_valid_en, wr_meta_en, wr_age_en;
   logic [IW-1:0]       wr_addr;
   logic                wr_valid_d;
   logic [MAC_W-1:0]    wr_mac_d;
   logic [PORT_W-1:0]   wr_port_d;
   logic [AGE_BITS-1:0] wr_age_d;

   always_ff @(posedge clock) begin
      if (wr_valid_en) mem_valid[wr_addr] <= wr_valid_d;
      if (wr_meta_en) begin
         mem_mac[wr_addr]  <= wr_mac_d;
         mem_port[wr_addr] <= wr_port_d;
      end
      if (wr_age_en) mem_age[wr_addr] <= wr_age_d;
      if (cmd.rd) begin
         rdv_ff    <= mem_valid[cnt_ff];
         rdmac_ff  <= mem_mac[cnt_ff];
         rdport_ff <= mem_port[cnt_ff];
         rdage_ff  <= mem_age[cnt_ff];
      end
   end

   // scan results
   logic              src_hit_ff, src_hit_in;
   logic [IW-1:0]     src_idx_ff, src_idx_in;
   logic              src_old_ff, src_old_in;
   logic [PORT_W-1:0] src_port_ff, src_port_in;
   logic              free_hit_ff, free_hit_in;
   logic [IW-1:0]     free_idx_ff, free_idx_in;
   logic              dst_hit_ff, dst_hit_in;
   logic [PORT_W-1:0] dst_port_ff, dst_port_in;

   logic frame_eval;
   assign frame_eval = rd_valid_ff && (item_ff.kind == KIND_FRAME);

   always_comb begin
      src_hit_in  = src_hit_ff;
      src_idx_in  = src_idx_ff;
      src_old_in  = src_old_ff;
      src_port_in = src_port_ff;
      free_hit_in = free_hit_ff;
      free_idx_in = free_idx_ff;
      dst_hit_in  = dst_hit_ff;
      dst_port_in = dst_port_ff;
      if (cmd.load) begin
         src_hit_in  = 1'b0;
         free_hit_in = 1'b0;
         dst_hit_in  = 1'b0;
      end else if (frame_eval) begin
         // first match wins, matching the lowest entry
         if (!src_hit_ff && rdv_ff && (rdmac_ff == item_ff.src_mac)) begin
            src_hit_in  = 1'b1;
            src_idx_in  = rd_addr_ff;
            src_old_in  = (CW'(rdage_ff) >= CW'(learn_timeout_ff));
            src_port_in = rdport_ff;
         end
         if (!free_hit_ff && !rdv_ff) begin
            free_hit_in = 1'b1;
            free_idx_in = rd_addr_ff;
         end
         if (!dst_hit_ff && rdv_ff && (rdmac_ff == item_ff.dst_mac)) begin
            dst_hit_in  = 1'b1;
            dst_port_in = rdport_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_hit_ff  <= 1'b0;
         free_hit_ff <= 1'b0;
         dst_hit_ff  <= 1'b0;
      end else begin
         src_hit_ff  <= src_hit_in;
         free_hit_ff <= free_hit_in;
         dst_hit_ff  <= dst_hit_in;
      end
      src_idx_ff  <= src_idx_in;
      src_old_ff  <= src_old_in;
      src_port_ff <= src_port_in;
      free_idx_ff <= free_idx_in;
      dst_port_ff <= dst_port_in;
   end

   // learning and forwarding decision
   logic              is_frame;
   logic              dropped;
   logic              same_mac;
   logic              found;
   logic [PORT_W-1:0] learn_port;
   logic [PORT_W-1:0] fwd_port;
   logic [OUT_W-1:0]  mask;
   rsp_type           result;

   always_comb begin
      is_frame   = (item_ff.kind == KIND_FRAME);
      learn_port = (src_hit_ff && !src_old_ff) ? src_port_ff : item_ff.in_port;
      dropped    = !src_hit_ff && !free_hit_ff;
      // a destination equal to the source sees the entry just learned
      same_mac   = (item_ff.src_mac == item_ff.dst_mac);
      found      = !item_ff.dst_flood && (same_mac ? !dropped : dst_hit_ff);
      fwd_port   = same_mac ? learn_port : dst_port_ff;
      if (found) begin
         mask = OUT_W'(1) << fwd_port;
      end else begin
         mask = active_mask_ff & PORT_RANGE & ~(OUT_W'(1) << item_ff.in_port);
      end
      if (is_frame) begin
         result.out_port_mask = mask;
         result.dest_found    = found;
         result.learn_dropped = dropped;
      end else begin
         result = '0;
      end
   end

   // aging of one entry read during a tick scan
   logic [AGE_BITS-1:0] tick_age;
   logic                tick_wr;

   assign tick_age = (rdage_ff == AGE_MAX) ? rdage_ff : rdage_ff + AGE_BITS'(1);
   assign tick_wr  = rd_valid_ff && (item_ff.kind == KIND_TICK) && rdv_ff;

   always_comb begin
      wr_valid_en = 1'b0;
      wr_meta_en  = 1'b0;
      wr_age_en   = 1'b0;
      wr_addr     = cnt_ff;
      wr_valid_d  = 1'b0;
      wr_mac_d    = item_ff.src_mac;
      wr_port_d   = learn_port;
      wr_age_d    = '0;
      if (cmd.clear_wr) begin
         wr_valid_en = 1'b1;
      end else if (tick_wr) begin
         wr_valid_en = 1'b1;
         wr_age_en   = 1'b1;
         wr_addr     = rd_addr_ff;
         wr_age_d    = tick_age;
         wr_valid_d  = !(CW'(tick_age) >= CW'(entry_ttl_ff));
      end else if (cmd.finish && is_frame && !dropped) begin
         wr_valid_en = 1'b1;
         wr_meta_en  = 1'b1;
         wr_age_en   = 1'b1;
         wr_addr     = src_hit_ff ? src_idx_ff : free_idx_ff;
         wr_valid_d  = 1'b1;
      end
   end

   // result register, frees the input side while a result waits
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_payload_ff;

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.finish) rsp_payload_ff <= result;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_payload   = rsp_payload_ff;
   assign stat.cnt_last = cnt_last;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

@@ src/mac_learning_bridge_table.sv @@
// channel  direction  handshake              payload
// req      in         req_valid / req_stall  req_payload (kind, macs, flood, port)
// rsp      out        rsp_valid / rsp_stall  rsp_payload (mask, found, dropped)
// csr      in         csr_wr_en              csr_index, csr_wdata
//
// each item scans the whole table through one memory read port, one entry per
// cycle, then passes a drain state and loads the result register from its finish state
// after reset a clearing pass over every table entry runs with req_stall high
// a result held by rsp_stall lets the next item scan, but that item's result
// waits in its final state until the result register is taken
module mac_learning_bridge_table import mlbt_pkg::*; #(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   parameter int NUM_PORTS     = DEF_NUM_PORTS,
   parameter int AGE_BITS      = DEF_AGE_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   mlbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mlbt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NUM_PORTS     (NUM_PORTS),
      .AGE_BITS      (AGE_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   logic rsp_hit;
   logic hit_mask_onehot;

   assign rsp_hit         = rsp_valid && rsp_payload.dest_found;
   assign hit_mask_onehot = $onehot(rsp_payload.out_port_mask);

`include "mac_learning_bridge_table_assert.svh"

   `MLBT_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "item overlap")
   `MLBT_ASSERT_SAME(a_hit_onehot, clock, reset, rsp_hit, hit_mask_onehot, "hit mask not one-hot")
   `MLBT_ASSERT_SAME(a_clear_stall, clock, reset, cmd.clear_wr, req_stall, "accept during clear")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
   import mlbt_pkg::*;

   localparam int ENTRIES = DEF_TABLE_ENTRIES;
   localparam int POOL_N = 96;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   mac_learning_bridge_table u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // shadow copy of the bridge table and its registers
   logic [CSR_W-1:0] cur_learn_timeout = LEARN_TIMEOUT_RST;
   logic [CSR_W-1:0] cur_entry_ttl = ENTRY_TTL_RST;
   logic [CSR_W-1:0] cur_active_mask = ACTIVE_MASK_RST;
   logic tbl_valid [ENTRIES];
   logic [MAC_W-1:0] tbl_mac [ENTRIES];
   logic [PORT_W-1:0] tbl_port [ENTRIES];
   logic [DEF_AGE_BITS-1:0] tbl_age [ENTRIES];

   req_type ingress_q[$];
   rsp_type decision_q[$];
   logic [MAC_W-1:0] host_mac [POOL_N];
   logic [PORT_W-1:0] host_port [POOL_N];

   int n_fail = 0;
   logic req_taken = 1'b0;
   int req_gap = 0;
   int stall_left = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;

   function automatic int find_entry(logic [MAC_W-1:0] mac);
      for (int i = 0; i < ENTRIES; i++)
         if (tbl_valid[i] && tbl_mac[i] == mac) return i;
      return -1;
   endfunction

   function automatic rsp_type bridge_decide(req_type r);
      rsp_type o;
      int hit;
      int slot;
      o = '0;
      if (r.kind == KIND_TICK) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tbl_valid[i]) begin
               if (tbl_age[i] != '1) tbl_age[i] = tbl_age[i] + 1'b1;
               if (tbl_age[i] >= cur_entry_ttl) tbl_valid[i] = 1'b0;
            end
         end
         return o;
      end
      // learn the source first
      hit = find_entry(r.src_mac);
      if (hit >= 0) begin
         if (tbl_age[hit] >= cur_learn_timeout) tbl_port[hit] = r.in_port;
         tbl_age[hit] = '0;
      end else begin
         slot = -1;
         for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i] && slot < 0) slot = i;
         if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_mac[slot] = r.src_mac;
            tbl_port[slot] = r.in_port;
            tbl_age[slot] = '0;
         end else begin
            o.learn_dropped = 1'b1;
         end
      end
      if (!r.dst_flood) begin
         hit = find_entry(r.dst_mac);
         if (hit >= 0) begin
            o.dest_found = 1'b1;
            o.out_port_mask = 8'b1 << tbl_port[hit];
         end
      end
      if (!o.dest_found) o.out_port_mask = cur_active_mask & ~(8'b1 << r.in_port);
      return o;
   endfunction

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[MAC_W-1:0];
   endfunction

   // mostly short gaps, a few long ones, none during a calm stretch
   function automatic int idle_len(bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   function automatic void push_frame(logic [MAC_W-1:0] src, logic [MAC_W-1:0] dst,
                                      logic flood, logic [PORT_W-1:0] port);
      req_type r;
      r.kind = KIND_FRAME;
      r.src_mac = src;
      r.dst_mac = dst;
      r.dst_flood = flood;
      r.in_port = port;
      ingress_q.insert(ingress_q.size(), r);
   endfunction

   function automatic void push_tick();
      req_type r;
      r.kind = KIND_TICK;
      r.src_mac = rand_mac();
      r.dst_mac = rand_mac();
      r.dst_flood = 1'($urandom_range(0, 1));
      r.in_port = 3'($urandom_range(0, 7));
      ingress_q.insert(ingress_q.size(), r);
   endfunction

   task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      n_fail++;
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_LEARN_TIMEOUT: cur_learn_timeout = val;
         CSR_ENTRY_TTL: cur_entry_ttl = val;
         CSR_ACTIVE_MASK: cur_active_mask = val;
         default: ;
      endcase
   endtask

   // wait until every transfer has its result back, then let the scan finish
   task automatic settle();
      while (ingress_q.size() != 0 || req_valid || decision_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // hosts keep their home port most of the time; some random macs as noise
   task automatic run_phase(logic [CSR_W-1:0] lt, logic [CSR_W-1:0] ttl,
                            logic [CSR_W-1:0] mask, int pool_n, int tick_pct, int n);
      int unsigned h;
      int unsigned r;
      logic [MAC_W-1:0] src;
      logic [MAC_W-1:0] dst;
      logic [PORT_W-1:0] port;
      settle();
      csr_write(CSR_LEARN_TIMEOUT, lt);
      csr_write(CSR_ENTRY_TTL, ttl);
      csr_write(CSR_ACTIVE_MASK, mask);
      @(posedge clock);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 99) < tick_pct) begin
            push_tick();
         end else begin
            h = $urandom_range(0, pool_n - 1);
            src = host_mac[h];
            port = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : host_port[h];
            if ($urandom_range(0, 9) == 0) src = rand_mac();
            r = $urandom_range(0, 99);
            if (r < 65) dst = host_mac[$urandom_range(0, pool_n - 1)];
            else if (r < 80) dst = src;
            else dst = rand_mac();
            push_frame(src, dst, $urandom_range(0, 7) == 0, port);
         end
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if ($urandom_range(0, 399) == 0) send_calm = !send_calm;
         if (!req_valid || req_taken) begin
            if (req_gap > 0 || ingress_q.size() == 0) begin
               req_valid <= 1'b0;
               if (req_gap > 0) req_gap--;
            end else begin
               req_payload <= ingress_q.pop_front();
               req_valid <= 1'b1;
               req_gap = idle_len(send_calm);
            end
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 399) == 0) recv_calm = !recv_calm;
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0) stall_left = idle_len(recv_calm);
         end
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (decision_q.size() == 0) begin
               report_mismatch("unexpected transfer", rsp_payload.out_port_mask, 8'h0);
            end else begin
               want = decision_q.pop_front();
               if (rsp_payload.out_port_mask !== want.out_port_mask)
                  report_mismatch("out_port_mask", rsp_payload.out_port_mask,
                                  want.out_port_mask);
               if (rsp_payload.dest_found !== want.dest_found)
                  report_mismatch("dest_found", 8'(rsp_payload.dest_found),
                                  8'(want.dest_found));
               if (rsp_payload.learn_dropped !== want.learn_dropped)
                  report_mismatch("learn_dropped", 8'(rsp_payload.learn_dropped),
                                  8'(want.learn_dropped));
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            decision_q.insert(decision_q.size(), bridge_decide(req_payload));
         end
      end
   end

   initial begin
      #60_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [MAC_W-1:0] mac_a;
      logic [MAC_W-1:0] mac_b;
      logic [MAC_W-1:0] mac_c;
      logic [MAC_W-1:0] mac_d;
      logic [MAC_W-1:0] mac_e;
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
      for (int i = 0; i < POOL_N; i++) begin
         host_mac[i] = rand_mac();
         host_port[i] = 3'($urandom_range(0, 7));
      end
      host_mac[0] = '0;
      host_mac[1] = '1;
      mac_a = rand_mac();
      mac_b = rand_mac();
      mac_c = rand_mac();
      mac_d = rand_mac();
      mac_e = rand_mac();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults, no active port: floods come out empty
      push_frame(mac_a, mac_b, 1'b0, 3'd0);
      push_frame(mac_b, mac_a, 1'b0, 3'd7);
      push_frame('0, '1, 1'b0, 3'd3);
      push_frame('1, '0, 1'b0, 3'd4);
      push_frame(mac_a, mac_a, 1'b0, 3'd2);
      push_frame(mac_a, mac_b, 1'b1, 3'd1);
      push_tick();

      // all ports active: miss and flood request skip the ingress port
      settle();
      csr_write(CSR_ACTIVE_MASK, 8'hFF);
      @(posedge clock);
      push_frame(mac_c, mac_d, 1'b0, 3'd5);
      push_frame(mac_c, mac_d, 1'b1, 3'd0);
      push_frame(mac_d, mac_c, 1'b0, 3'd6);
      push_frame(mac_c, mac_c, 1'b1, 3'd7);

      // zero learn timeout replaces the port, short ttl expires entries
      settle();
      csr_write(CSR_LEARN_TIMEOUT, 8'd0);
      csr_write(CSR_ENTRY_TTL, 8'd2);
      csr_write(CSR_SPARE, 8'hFF);
      @(posedge clock);
      push_frame(mac_a, mac_a, 1'b0, 3'd6);
      push_tick();
      push_frame(mac_e, mac_a, 1'b0, 3'd2);
      push_tick();
      push_frame(mac_e, mac_a, 1'b0, 3'd1);
      push_frame(mac_b, mac_e, 1'b0, 3'd3);

      run_phase(8'd30, 8'd100, 8'hFF, POOL_N, 2, 400);
      run_phase(8'd0, 8'd255, 8'hA5, 24, 10, 300);
      run_phase(8'd255, 8'd3, 8'h5A, 40, 25, 300);
      run_phase(8'd2, 8'd6, 8'($urandom), 70, 15, 350);
      run_phase(8'd255, 8'd0, 8'h00, 16, 10, 200);
      run_phase(8'd5, 8'd20, 8'($urandom), POOL_N, 5, 380);
      settle();

      if (n_fail == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+src
src/mlbt_pkg.sv
src/mlbt_ctrl.sv
src/mlbt_dpath.sv
src/mac_learning_bridge_table.sv
tb/tb_top.sv
